// ===== rtl/assert_macros.svh =====
// Assertion macros used by the console writer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TCW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TCW_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define TCW_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Types, request codes and character constants of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Width of one stored cell: character in the upper byte, attribute below
    localparam int CELL_W = 16;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_BACK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Character codes
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_STAR    = 8'd42;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  attr;
        logic        masked;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
    } t_out_item;

endpackage

// ===== rtl/text_console_writer.sv =====
// Text console writer top level: request sequencer around the screen memory.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+-------------------------
//  request | i_in_valid | o_in_ready  | i_in_item  (t_in_item)
//  result  | o_out_valid| i_out_ready | o_out_item (t_out_item)
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_data (blank_attr)
//
// A put without scroll and a backspace at cell 0 do a cell write or cursor update,
// then the result load; a read or a backspace does a memory read, then a write
// back or capture, then the result load. Clear and scroll sweep all COLUMNS*ROWS
// cells, one cell per cycle over the single write port of the screen memory,
// before the result load.
// After reset every cell of the memory is swept to a blank cell while
// no request is taken; configuration writes are taken throughout.
// A stalled result holds the result register and blocks the next request.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int KEEP       = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int XW         = (AW + 1 > 11) ? AW + 1 : 11;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_SCRL0 = 3'd2;
    localparam logic [2:0] S_SCRL  = 3'd3;
    localparam logic [2:0] S_RMW   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_cursor, n_cursor;
    logic [CW-1:0]     r_col, n_col;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_init, n_init;
    logic              r_back, n_back;
    logic              r_rd_ok, n_rd_ok;
    logic              r_scrolled, n_scrolled;
    logic [CELL_W-1:0] r_rd, n_rd;
    logic [7:0]        r_blank;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              w_accept;
    logic              w_out_free;
    logic              w_newline;
    logic [7:0]        w_char;
    logic [AW-1:0]     w_cur_next;
    logic [CW-1:0]     w_col_next;
    logic              w_scroll;
    logic              w_back_write;
    logic [XW-1:0]     w_idx_ext;
    logic              w_idx_ok;
    logic [AW:0]       w_src;
    logic [XW-1:0]     w_cur_ext;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [CELL_W-1:0] w_rdata;

    // Screen memory
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Cursor arithmetic
    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW),
        .CW      (CW)
    ) u_cursor (
        .i_req        (i_in_item.req_type),
        .i_newline    (w_newline),
        .i_cursor     (r_cursor),
        .i_col        (r_col),
        .o_cursor     (w_cur_next),
        .o_col        (w_col_next),
        .o_scroll     (w_scroll),
        .o_back_write (w_back_write)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Masking wins over newline
    assign w_char    = i_in_item.masked ? CH_STAR : i_in_item.char_code;
    assign w_newline = (w_char == CH_NEWLINE);

    assign w_idx_ext = XW'(i_in_item.cell_index);
    assign w_idx_ok  = (w_idx_ext < XW'(CELL_COUNT));
    assign w_src     = {1'b0, r_addr} + (AW+1)'(COLUMNS + 1);
    assign w_cur_ext = XW'(r_cursor);

    // Sequence requests and memory sweeps
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_addr      = r_addr;
        n_init      = r_init;
        n_back      = r_back;
        n_rd_ok     = r_rd_ok;
        n_scrolled  = r_scrolled;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_cursor;
        w_wdata     = {CH_SPACE, r_blank};
        w_re        = 1'b0;
        w_raddr     = r_cursor;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cursor   = w_cur_next;
                    n_col      = w_col_next;
                    n_scrolled = 1'b0;
                    n_rd       = '0;
                    case (i_in_item.req_type)
                        REQ_PUT: begin
                            if (!w_newline) begin
                                w_we    = 1'b1;
                                w_waddr = r_cursor;
                                w_wdata = {w_char, i_in_item.attr};
                            end
                            if (w_scroll) begin
                                n_scrolled = 1'b1;
                                n_state    = S_SCRL0;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_BACK: begin
                            n_back = 1'b1;
                            if (w_back_write) begin
                                w_re    = 1'b1;
                                w_raddr = w_cur_next;
                                n_state = S_RMW;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        REQ_CLEAR: begin
                            n_addr  = '0;
                            n_init  = 1'b0;
                            n_state = S_FILL;
                        end
                        default: begin
                            n_back  = 1'b0;
                            n_rd_ok = w_idx_ok;
                            w_re    = 1'b1;
                            w_raddr = w_idx_ok ? w_idx_ext[AW-1:0] : '0;
                            n_state = S_RMW;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = {CH_SPACE, (r_init ? 8'd0 : r_blank)};
                if (r_addr == AW'(CELL_COUNT - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_SCRL0: begin
                w_re    = 1'b1;
                w_raddr = AW'(COLUMNS);
                n_addr  = '0;
                n_state = S_SCRL;
            end
            S_SCRL: begin
                // Copy one cell up a row, or blank it in the bottom row
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = (r_addr < AW'(KEEP)) ? w_rdata : {CH_SPACE, r_blank};
                if (w_src < (AW+1)'(CELL_COUNT)) begin
                    w_re    = 1'b1;
                    w_raddr = w_src[AW-1:0];
                end
                if (r_addr == AW'(CELL_COUNT - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_RMW: begin
                if (r_back) begin
                    // Blank the character, keep the attribute
                    w_we    = 1'b1;
                    w_waddr = r_cursor;
                    w_wdata = {CH_SPACE, w_rdata[7:0]};
                end else begin
                    n_rd = r_rd_ok ? w_rdata : '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cursor_pos = w_cur_ext[10:0];
                    n_out.read_char  = r_rd[15:8];
                    n_out.read_attr  = r_rd[7:0];
                    n_out.scrolled   = r_scrolled;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_cursor    <= '0;
            r_col       <= '0;
            r_addr      <= '0;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
            r_blank     <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_addr      <= n_addr;
            r_init      <= n_init;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_blank <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_back     <= n_back;
        r_rd_ok    <= n_rd_ok;
        r_scrolled <= n_scrolled;
        r_rd       <= n_rd;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TCW_ASSERT(a_cursor_range, i_clk, i_rst_n, {1'b0, r_cursor} < (AW+1)'(CELL_COUNT), "cursor out of range")
    `TCW_ASSERT(a_col_range, i_clk, i_rst_n, {1'b0, r_col} < (CW+1)'(COLUMNS), "column out of range")
    `TCW_ASSERT_IMP(a_idle_write, i_clk, i_rst_n, w_we && (r_state == S_IDLE), w_accept && (i_in_item.req_type == REQ_PUT), "memory write while idle without a put")
    `TCW_ASSERT_NEXT(a_result_load, i_clk, i_rst_n, (r_state == S_DONE) && w_out_free, o_out_valid && (r_state == S_IDLE), "result not loaded at the end of a request")

endmodule

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tcw_cursor.sv =====
// Next cursor position, column and scroll decision for one request.
`timescale 1ns / 1ps
module tcw_cursor
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int AW      = $clog2(COLUMNS * ROWS),
    parameter int CW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  logic [1:0]    i_req,
    input  logic          i_newline,
    input  logic [AW-1:0] i_cursor,
    input  logic [CW-1:0] i_col,
    output logic [AW-1:0] o_cursor,
    output logic [CW-1:0] o_col,
    output logic          o_scroll,
    output logic          o_back_write
);

    localparam int CELL_COUNT = COLUMNS * ROWS;

    logic [AW:0] w_cur;
    logic [AW:0] w_put;
    logic [AW:0] w_next;
    logic        w_wrap;

    assign w_cur  = {1'b0, i_cursor};
    // Newline jumps to the start of the next row, a character steps one cell
    assign w_put  = i_newline ? (w_cur + ((AW+1)'(COLUMNS) - (AW+1)'(i_col)))
                              : (w_cur + (AW+1)'(1));
    assign w_wrap = (w_put >= (AW+1)'(CELL_COUNT));
    assign w_next = w_wrap ? (w_put - (AW+1)'(COLUMNS)) : w_put;

    // Decode the request
    always_comb begin
        o_cursor     = i_cursor;
        o_col        = i_col;
        o_scroll     = 1'b0;
        o_back_write = 1'b0;
        unique case (i_req)
            REQ_PUT: begin
                o_cursor = w_next[AW-1:0];
                o_scroll = w_wrap;
                if (i_newline || (i_col == CW'(COLUMNS - 1))) begin
                    o_col = '0;
                end else begin
                    o_col = i_col + CW'(1);
                end
            end
            REQ_BACK: begin
                if (i_cursor != '0) begin
                    o_cursor     = i_cursor - AW'(1);
                    o_back_write = 1'b1;
                    o_col        = (i_col == '0) ? CW'(COLUMNS - 1) : (i_col - CW'(1));
                end
            end
            REQ_CLEAR: begin
                o_cursor = '0;
                o_col    = '0;
            end
            REQ_READ: begin
                o_cursor = i_cursor;
            end
            default: begin
                o_cursor = i_cursor;
            end
        endcase
    end

endmodule

// ===== tb/sv/tcw_tb_pkg.sv =====
// Shadow model of the console screen used to predict and check result items.
`timescale 1ns / 1ps
package tcw_tb_pkg;
    import tcw_pkg::*;

    localparam int SCR_COLS  = DEF_COLUMNS;
    localparam int SCR_ROWS  = DEF_ROWS;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

    class console_shadow;
        logic [7:0]  blank_attr;
        int unsigned cursor;
        logic [7:0]  cell_char [SCR_CELLS];
        logic [7:0]  cell_attr [SCR_CELLS];
        t_out_item   awaited_replies [$];
        int          failures;
        int          requests;
        int          reads;
        int          clears;
        int          scrolls;

        function new();
            blank_attr = '0;
            cursor     = 0;
            failures   = 0;
            requests   = 0;
            reads      = 0;
            clears     = 0;
            scrolls    = 0;
            blank_from(0);
        endfunction

        // Fill cells from the given index to the end of the screen with blanks
        function void blank_from(int first);
            for (int i = first; i < SCR_CELLS; i++) begin
                cell_char[i] = CH_SPACE;
                cell_attr[i] = blank_attr;
            end
        endfunction

        // Move every row up by one and blank the bottom row
        function void scroll_one_row();
            for (int i = 0; i < SCR_CELLS - SCR_COLS; i++) begin
                cell_char[i] = cell_char[i + SCR_COLS];
                cell_attr[i] = cell_attr[i + SCR_COLS];
            end
            blank_from(SCR_CELLS - SCR_COLS);
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        // Apply one accepted request to the shadow screen and queue its reply
        function void apply_request(t_in_item it);
            t_out_item  reply;
            logic [7:0] ch;
            reply = '0;
            requests++;
            if (cursor >= SCR_CELLS) begin
                cursor = 0;
            end
            case (it.req_type)
                REQ_PUT: begin
                    ch = it.masked ? CH_STAR : it.char_code;
                    if (ch == CH_NEWLINE) begin
                        cursor = (cursor / SCR_COLS + 1) * SCR_COLS;
                    end else begin
                        cell_char[cursor] = ch;
                        cell_attr[cursor] = it.attr;
                        cursor++;
                    end
                    if (cursor >= SCR_CELLS) begin
                        cursor -= SCR_COLS;
                        scroll_one_row();
                        reply.scrolled = 1'b1;
                        scrolls++;
                    end
                end
                REQ_BACK: begin
                    // Ignore at cell 0; otherwise blank only the character
                    if (cursor > 0) begin
                        cursor--;
                        cell_char[cursor] = CH_SPACE;
                    end
                end
                REQ_CLEAR: begin
                    blank_from(0);
                    cursor = 0;
                    clears++;
                end
                REQ_READ: begin
                    reads++;
                    if (it.cell_index < SCR_CELLS) begin
                        reply.read_char = cell_char[it.cell_index];
                        reply.read_attr = cell_attr[it.cell_index];
                    end
                end
            endcase
            reply.cursor_pos = 11'(cursor);
            awaited_replies.push_back(reply);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        // Check one result item against the oldest queued reply
        function void check_reply(t_out_item got);
            t_out_item want;
            if (awaited_replies.size() == 0) begin
                $display("%0t ns: result item with none expected, expected none, actual %h",
                         $time, got);
                failures++;
                return;
            end
            want = awaited_replies.pop_front();
            compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
            compare_field("read_char",  want.read_char,  got.read_char);
            compare_field("read_attr",  want.read_attr,  got.read_attr);
            compare_field("scrolled",   want.scrolled,   got.scrolled);
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_text_console_writer.sv =====
// Top-level testbench of the text console writer: stimulus, stalls and checking.
`timescale 1ns / 1ps
module tb_text_console_writer;
    import tcw_pkg::*;
    import tcw_tb_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    console_shadow screen;
    bit            gaps_enabled    = 1'b1;
    int            out_hold_cycles = 0;
    int            attr_settings   = 0;

    text_console_writer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int draw_gap();
        return gaps_enabled ? $urandom_range(0, 5) : 0;
    endfunction

    function automatic t_in_item make_req(logic [1:0] kind, logic [7:0] ch, logic [7:0] at,
                                          logic m, logic [10:0] idx);
        t_in_item it;
        it.req_type   = kind;
        it.char_code  = ch;
        it.attr       = at;
        it.masked     = m;
        it.cell_index = idx;
        return it;
    endfunction

    // Mostly text lines and reads of the screen, with some backspaces and rare clears
    function automatic t_in_item random_request();
        t_in_item it;
        int       pick;
        int       where;
        it.char_code  = 8'($urandom);
        it.attr       = 8'($urandom);
        it.masked     = 1'($urandom);
        it.cell_index = 11'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 3) begin
            it.req_type = REQ_CLEAR;
        end else if (pick < 130) begin
            it.req_type = REQ_BACK;
        end else if (pick < 280) begin
            it.req_type = REQ_READ;
            where = $urandom_range(0, 9);
            if (where < 5) begin
                it.cell_index = 11'($urandom_range(0, SCR_CELLS - 1));
            end else if (where < 9) begin
                it.cell_index = 11'((screen.cursor >= 40) ?
                                    screen.cursor - $urandom_range(0, 40) :
                                    $urandom_range(0, 40));
            end else begin
                it.cell_index = 11'($urandom_range(SCR_CELLS, 2047));
            end
        end else begin
            it.req_type = REQ_PUT;
            if ($urandom_range(0, 3) == 0) begin
                it.char_code = CH_NEWLINE;
            end
            it.masked = ($urandom_range(0, 9) == 0);
        end
        return it;
    endfunction

    // Offer one request item and hold it until accepted
    task automatic send_request(input t_in_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        screen.apply_request(it);
    endtask

    // Drop valid and wait until every queued reply has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (screen.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_blank_attr(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        screen.blank_attr = value;
        attr_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(random_request());
        end
    endtask

    task automatic run_directed();
        // Backspace at the home cell, then a read of the reset screen
        send_request(make_req(REQ_BACK, 8'hFF, 8'hFF, 1'b1, 11'h7FF));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd0));
        // Extreme character and attribute bytes
        send_request(make_req(REQ_PUT, 8'hFF, 8'hFF, 1'b0, 11'd0));
        send_request(make_req(REQ_PUT, 8'h00, 8'h00, 1'b0, 11'd0));
        // Masked newline writes an asterisk
        send_request(make_req(REQ_PUT, CH_NEWLINE, 8'hA5, 1'b1, 11'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd2));
        // Newline, one character, then back over it and across the row start
        send_request(make_req(REQ_PUT, CH_NEWLINE, 8'h3C, 1'b0, 11'd0));
        send_request(make_req(REQ_PUT, 8'h78, 8'h5A, 1'b0, 11'd0));
        send_request(make_req(REQ_BACK, 8'h00, 8'h00, 1'b0, 11'd0));
        send_request(make_req(REQ_BACK, 8'h00, 8'h00, 1'b0, 11'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd80));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd79));
        // Last cell and reads past the end of the screen
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'(SCR_CELLS - 1)));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'(SCR_CELLS)));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'h7FF));
        // Clear, then check the home cells
        send_request(make_req(REQ_CLEAR, 8'h55, 8'hAA, 1'b1, 11'h400));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd1));
        send_request(make_req(REQ_PUT, 8'h7F, 8'h80, 1'b0, 11'd0));
        send_request(make_req(REQ_READ, 8'h00, 8'h00, 1'b0, 11'd0));
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int gap;
        // Hold off until reset is released
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (out_hold_cycles > 0) begin
                gap = out_hold_cycles;
                out_hold_cycles = 0;
            end else begin
                gap = draw_gap();
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            screen.check_reply(o_out_item);
        end
    end

    // Main sequence: reset, directed items, then random phases per setting
    initial begin : main_flow
        screen = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        settle();

        // Hold off the result side for a long stretch while requests are offered
        write_blank_attr(8'hFF);
        out_hold_cycles = 300;
        run_random(300);
        settle();

        // No gaps on either side
        write_blank_attr(8'h00);
        gaps_enabled = 1'b0;
        run_random(250);
        settle();

        // Pause the request side mid-phase until the screen drains
        gaps_enabled = 1'b1;
        write_blank_attr(8'($urandom));
        run_random(150);
        settle();
        run_random(150);
        settle();

        write_blank_attr(8'h81);
        run_random(150);
        settle();

        $display("Covered %0d requests: %0d reads, %0d clears, %0d scrolls",
                 screen.requests, screen.reads, screen.clears, screen.scrolls);
        $display("Blank attribute set %0d times, %0d mismatches",
                 attr_settings, screen.failures);
        if (screen.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #25_000_000;
        $display("Timeout with %0d results still awaited", screen.pending());
        $display("TB_ERROR");
        $finish;
    end

endmodule
